// ===== hdl/hgad_pkg.sv =====
// Shared types and constants of the headway gap acceleration decision block.
`timescale 1ns / 1ps
`default_nettype none
package hgad_pkg;

	// Decision codes carried on the result stream.
	typedef enum logic [1:0] {
		ACT_HOLD  = 2'd0,
		ACT_ACCEL = 2'd1,
		ACT_BRAKE = 2'd2
	} action_t;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_GAP     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_HEADWAY     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_BIAS_GAIN   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_DEADBAND    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_BRAKE_LIMIT = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_LIMIT = 3'd5;

	// Register reset values.
	localparam logic [15:0] MIN_GAP_RST     = 16'd1280;
	localparam logic [11:0] HEADWAY_RST     = 12'd384;
	localparam logic [15:0] BIAS_GAIN_RST   = 16'd128;
	localparam logic [15:0] DEADBAND_RST    = 16'd256;
	localparam logic [15:0] BRAKE_LIMIT_RST = 16'd768;
	localparam logic [14:0] ACCEL_LIMIT_RST = 15'd384;

	// Field and datapath widths.
	localparam int CFG_DATA_W = 16;
	localparam int SPEED_W    = 16;
	localparam int GAP_W      = 24;
	localparam int HEADWAY_W  = 12;
	localparam int ERR_W      = 25;
	localparam int BIAS_W     = 24;
	localparam int MAG_W      = 24;
	localparam int NUM_W      = 32;
	localparam int REQ_W      = 16;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	// Pipeline shape: three front stages, the divider, one output stage.
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = NUM_W / DIV_STEPS;
	localparam int DIV_FIRST  = 4;
	localparam int NUM_STAGES = DIV_FIRST + DIV_STAGES;

	// Working word of the restoring divider: partial remainder plus
	// numerator bits still to shift in, with quotient bits entering at the bottom.
	typedef struct packed {
		logic [HEADWAY_W-1:0] rem;
		logic [NUM_W-1:0]     nq;
	} div_work_t;

endpackage
`default_nettype wire

// ===== hdl/headway_gap_accel_decision.sv =====
// Top level: pipelined constant time headway cruise decision.
//
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       ego_speed, lead_speed, gap_distance
// m_*       out        m_tvalid / m_tready       action_code, accel_request
// cfg_*     in         cfg_we (no wait)          register index and write data
//
// One request is taken every cycle while the pipeline does not stall; the pipeline depth is set by
// the 32 step restoring divider at four steps a stage.
// Reset returns every configuration register to its default and empties the pipeline.
// A stalled output holds the last stage; empty stages further back still fill.
`timescale 1ns / 1ps
`default_nettype none
module headway_gap_accel_decision (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// ego_speed [15:0], lead_speed [31:16], gap_distance [55:32]
	input  wire logic [hgad_pkg::IN_DATA_W-1:0]        s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// action_code [1:0], accel_request [17:2], zero fill [23:18]
	output logic [hgad_pkg::OUT_DATA_W-1:0]            m_tdata,
	input  wire logic                                  cfg_we,
	input  wire logic [hgad_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire logic [hgad_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	localparam int NS = hgad_pkg::NUM_STAGES;
	localparam int DS = hgad_pkg::DIV_STAGES;

	// Configuration registers.
	logic [15:0]                      min_gap_q;
	logic [hgad_pkg::HEADWAY_W-1:0]   headway_q;
	logic [15:0]                      bias_gain_q;
	logic [15:0]                      deadband_q;
	logic [15:0]                      brake_limit_q;
	logic [14:0]                      accel_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q     <= hgad_pkg::MIN_GAP_RST;
			headway_q     <= hgad_pkg::HEADWAY_RST;
			bias_gain_q   <= hgad_pkg::BIAS_GAIN_RST;
			deadband_q    <= hgad_pkg::DEADBAND_RST;
			brake_limit_q <= hgad_pkg::BRAKE_LIMIT_RST;
			accel_limit_q <= hgad_pkg::ACCEL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				hgad_pkg::CFG_MIN_GAP:     min_gap_q     <= cfg_wdata;
				hgad_pkg::CFG_HEADWAY:     headway_q     <= cfg_wdata[hgad_pkg::HEADWAY_W-1:0];
				hgad_pkg::CFG_BIAS_GAIN:   bias_gain_q   <= cfg_wdata;
				hgad_pkg::CFG_DEADBAND:    deadband_q    <= cfg_wdata;
				hgad_pkg::CFG_BRAKE_LIMIT: brake_limit_q <= cfg_wdata;
				hgad_pkg::CFG_ACCEL_LIMIT: accel_limit_q <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// A zero headway divides by one.
	logic [hgad_pkg::HEADWAY_W-1:0] divisor;
	assign divisor = (headway_q == '0) ? hgad_pkg::HEADWAY_W'(1) : headway_q;

	// Valid bits and per-stage advance: a stage moves when it is empty or
	// when the stage after it moves, so bubbles close up behind a stall.
	logic [NS:1] stg_vld_q;
	logic [NS:1] stg_en;
	logic [NS:1] vld_in;

	always_comb begin
		stg_en[NS] = !stg_vld_q[NS] || m_tready;
		for (int k = NS - 1; k >= 1; k--) begin
			stg_en[k] = !stg_vld_q[k] || stg_en[k+1];
		end
	end

	assign vld_in   = {stg_vld_q[NS-1:1], s_tvalid};
	assign s_tready = stg_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			stg_vld_q <= (vld_in & stg_en) | (stg_vld_q & ~stg_en);
		end
	end

	// Stage 1: headway product, closing speed and the closing-rate check.
	logic [hgad_pkg::SPEED_W-1:0] ego_in;
	logic [hgad_pkg::SPEED_W-1:0] lead_in;
	logic [hgad_pkg::GAP_W-1:0]   gap_in;
	logic signed [16:0]           spd_diff;

	assign ego_in   = s_tdata[15:0];
	assign lead_in  = s_tdata[31:16];
	assign gap_in   = s_tdata[55:32];
	assign spd_diff = $signed({1'b0, ego_in}) - $signed({1'b0, lead_in});

	logic [27:0]                prod_h_s1;
	logic [15:0]                close_mag_s1;
	logic                       close_ok_s1;
	logic [hgad_pkg::GAP_W-1:0] gap_s1;

	always_ff @(posedge clk) begin
		if (stg_en[1]) begin
			prod_h_s1    <= ego_in * headway_q;
			close_mag_s1 <= (spd_diff > 17'sd0) ? spd_diff[15:0] : 16'd0;
			close_ok_s1  <= !(spd_diff > 17'sd128);
			gap_s1       <= gap_in;
		end
	end

	// Stage 2: gap error against the desired gap, and the closing bias.
	logic [20:0]       desired;
	logic [31:0]       bias_prod;
	logic signed [hgad_pkg::ERR_W-1:0] err_s2;
	logic [hgad_pkg::BIAS_W-1:0]       bias_s2;
	logic                               close_ok_s2;

	assign desired   = {5'd0, min_gap_q} + {1'b0, prod_h_s1[27:8]};
	assign bias_prod = bias_gain_q * close_mag_s1;

	always_ff @(posedge clk) begin
		if (stg_en[2]) begin
			err_s2      <= $signed({1'b0, gap_s1}) - $signed({4'd0, desired});
			bias_s2     <= bias_prod[31:8];
			close_ok_s2 <= close_ok_s1;
		end
	end

	// Stage 3: pick the action and form the scaled numerator.
	// The brake sum carries a spare bit, as a large error plus a large
	// threshold can reach beyond the range of the error itself.
	logic [24:0]                 brake_thr;
	logic signed [26:0]          brake_sum;
	logic                        do_brake;
	logic                        do_accel;
	logic [hgad_pkg::ERR_W-1:0]  err_neg;
	hgad_pkg::action_t           code_c3;
	logic [hgad_pkg::MAG_W-1:0]  mag_c3;

	assign brake_thr = {9'd0, deadband_q} + {1'b0, bias_s2};
	assign brake_sum = 27'(err_s2) + $signed({2'b0, brake_thr});
	assign do_brake  = brake_sum[26];
	assign do_accel  = (err_s2 > $signed({9'd0, deadband_q})) && close_ok_s2;
	assign err_neg   = -err_s2;

	always_comb begin
		if (do_brake) begin
			code_c3 = hgad_pkg::ACT_BRAKE;
			mag_c3  = err_neg[hgad_pkg::MAG_W-1:0];
		end else if (do_accel) begin
			code_c3 = hgad_pkg::ACT_ACCEL;
			mag_c3  = err_s2[hgad_pkg::MAG_W-1:0];
		end else begin
			code_c3 = hgad_pkg::ACT_HOLD;
			mag_c3  = '0;
		end
	end

	hgad_pkg::action_t            code_s3;
	logic [hgad_pkg::NUM_W-1:0]   num_s3;

	always_ff @(posedge clk) begin
		if (stg_en[3]) begin
			code_s3 <= code_c3;
			num_s3  <= {mag_c3, 8'd0};
		end
	end

	// Four restoring division steps on the working word.
	function automatic hgad_pkg::div_work_t div_steps(input hgad_pkg::div_work_t w,
			input logic [hgad_pkg::HEADWAY_W-1:0] d);
		hgad_pkg::div_work_t r;
		logic [hgad_pkg::HEADWAY_W:0] t;
		r = w;
		for (int i = 0; i < hgad_pkg::DIV_STEPS; i++) begin
			t = {r.rem, r.nq[hgad_pkg::NUM_W-1]};
			if (t >= {1'b0, d}) begin
				t    = t - {1'b0, d};
				r.nq = {r.nq[hgad_pkg::NUM_W-2:0], 1'b1};
			end else begin
				r.nq = {r.nq[hgad_pkg::NUM_W-2:0], 1'b0};
			end
			r.rem = t[hgad_pkg::HEADWAY_W-1:0];
		end
		return r;
	endfunction

	// Divider stages: each one retires four quotient bits.
	hgad_pkg::div_work_t div_src [DS];
	hgad_pkg::div_work_t div_w_s [DS];
	hgad_pkg::action_t   div_code_s [DS];
	hgad_pkg::action_t   div_code_src [DS];

	always_comb begin
		div_src[0].rem  = '0;
		div_src[0].nq   = num_s3;
		div_code_src[0] = code_s3;
		for (int g = 1; g < DS; g++) begin
			div_src[g]      = div_w_s[g-1];
			div_code_src[g] = div_code_s[g-1];
		end
	end

	for (genvar g = 0; g < DS; g++) begin : g_div
		always_ff @(posedge clk) begin
			if (stg_en[hgad_pkg::DIV_FIRST+g]) begin
				div_w_s[g]    <= div_steps(div_src[g], divisor);
				div_code_s[g] <= div_code_src[g];
			end
		end
	end

	// Output stage: clamp the quotient to the limit of the chosen action.
	logic [hgad_pkg::NUM_W-1:0] quot;
	logic [15:0]                brake_need;
	logic [14:0]                accel_want;
	logic [hgad_pkg::REQ_W-1:0] req_c;

	assign quot       = div_w_s[DS-1].nq;
	assign brake_need = (quot > {16'd0, brake_limit_q}) ? brake_limit_q : quot[15:0];
	assign accel_want = (quot > {17'd0, accel_limit_q}) ? accel_limit_q : quot[14:0];

	always_comb begin
		case (div_code_s[DS-1])
			hgad_pkg::ACT_BRAKE: begin
				if (brake_need[15] && (brake_need[14:0] != '0)) begin
					req_c = 16'h8000;
				end else begin
					req_c = 16'd0 - brake_need;
				end
			end
			hgad_pkg::ACT_ACCEL: req_c = {1'b0, accel_want};
			default:             req_c = '0;
		endcase
	end

	hgad_pkg::action_t          code_s12;
	logic [hgad_pkg::REQ_W-1:0] req_s12;

	always_ff @(posedge clk) begin
		if (stg_en[NS]) begin
			code_s12 <= div_code_s[DS-1];
			req_s12  <= req_c;
		end
	end

	assign m_tvalid = stg_vld_q[NS];
	assign m_tdata  = {6'd0, req_s12, code_s12};

`ifndef ASSERT_OFF
	// A hold decision never carries a request.
	a_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (code_s12 == hgad_pkg::ACT_HOLD) |-> req_s12 == '0)
		else $error("hold result with non-zero request");

	// An acceleration stays positive and within its limit.
	a_accel_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (code_s12 == hgad_pkg::ACT_ACCEL)
			|-> !req_s12[15] && (req_s12[14:0] <= accel_limit_q))
		else $error("acceleration request out of range");

	// A braking request is never positive.
	a_brake_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (code_s12 == hgad_pkg::ACT_BRAKE) |-> req_s12[15] || (req_s12 == '0))
		else $error("braking request is positive");

	// With the output stage empty, the whole chain advances and a request is taken.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!stg_vld_q[NS] |-> s_tready)
		else $error("input stalled with an empty output stage");
`endif

endmodule
`default_nettype wire
